### hw/rtl/vd2_pkg.sv
`default_nettype none

package vd2_pkg;

  // Component width of the x and y inputs.
  localparam int COMPONENT_BITS = 16;

  // CORDIC datapath: components are pre-shifted so a full-scale magnitude (2^15)
  // sits at bit 59; 62 signed bits cover the growth of the rotation.
  localparam int PRE_SHIFT = 60 - COMPONENT_BITS;
  localparam int CX_W      = 62;
  localparam int NUM_STEPS = 32;
  localparam int Z_W       = 32;
  localparam int A_W       = 32;
  localparam int ANGLE_W   = 16;
  localparam int PROD_W    = 64;

  localparam logic signed [Z_W-1:0] QUARTER_TURN = 32'sd1073741824;
  localparam logic [A_W:0] HALF_TURN = 33'h0_8000_0000;
  localparam logic [A_W:0] FULL_TURN = 33'h1_0000_0000;

  // round(2*pi * 2^29) and 360 * 128
  localparam logic [A_W-1:0] RAD_SCALE = 32'd3373259426;
  localparam logic [A_W-1:0] DEG_SCALE = 32'd46080;
  localparam logic [ANGLE_W-1:0] RAD_FULL = 16'd51472;
  localparam logic [ANGLE_W-1:0] DEG_FULL = 16'd46080;

  typedef struct packed {
    logic signed [COMPONENT_BITS-1:0] x_value;
    logic signed [COMPONENT_BITS-1:0] y_value;
  } in_req_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               zero_vector;
  } out_req_t;

  // Quadrant and zero-vector info riding alongside the CORDIC data
  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic zero;
  } vd2_side_t;

  typedef struct packed {
    logic signed [CX_W-1:0] cx;
    logic signed [CX_W-1:0] cy;
    logic signed [Z_W-1:0]  z;
    vd2_side_t              side;
  } vd2_rot_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [Z_W-1:0] step_angle(input int idx);
    logic signed [Z_W-1:0] r;
    case (idx)
      0:  r = 32'sd536870912;
      1:  r = 32'sd316933406;
      2:  r = 32'sd167458907;
      3:  r = 32'sd85004756;
      4:  r = 32'sd42667331;
      5:  r = 32'sd21354465;
      6:  r = 32'sd10679838;
      7:  r = 32'sd5340245;
      8:  r = 32'sd2670163;
      9:  r = 32'sd1335087;
      10: r = 32'sd667544;
      11: r = 32'sd333772;
      12: r = 32'sd166886;
      13: r = 32'sd83443;
      14: r = 32'sd41722;
      15: r = 32'sd20861;
      16: r = 32'sd10430;
      17: r = 32'sd5215;
      18: r = 32'sd2608;
      19: r = 32'sd1304;
      20: r = 32'sd652;
      21: r = 32'sd326;
      22: r = 32'sd163;
      23: r = 32'sd81;
      24: r = 32'sd41;
      25: r = 32'sd20;
      26: r = 32'sd10;
      27: r = 32'sd5;
      28: r = 32'sd3;
      29: r = 32'sd1;
      30: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/vd2_front.sv
`default_nettype none

module vd2_front import vd2_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_valid,
  input  in_req_t  in_data,
  output logic     out_valid,
  output vd2_rot_t out_rot
);

  logic                      valid_r;
  vd2_rot_t                  rot_r;
  vd2_rot_t                  rot_nxt;
  logic                      x_neg, y_neg;
  logic [COMPONENT_BITS-1:0] x_mag, y_mag;
  logic [CX_W-1:0]           x_ext, y_ext;

  // Two's complement magnitude; the most negative value maps to 2^(N-1)
  always_comb begin
    x_neg = in_data.x_value[COMPONENT_BITS-1];
    y_neg = in_data.y_value[COMPONENT_BITS-1];
    x_mag = x_neg ? (~in_data.x_value + 1'b1) : in_data.x_value;
    y_mag = y_neg ? (~in_data.y_value + 1'b1) : in_data.y_value;
    x_ext = {{(CX_W-COMPONENT_BITS){1'b0}}, x_mag} << PRE_SHIFT;
    y_ext = {{(CX_W-COMPONENT_BITS){1'b0}}, y_mag} << PRE_SHIFT;
    rot_nxt.cx         = $signed(x_ext);
    rot_nxt.cy         = $signed(y_ext);
    rot_nxt.z          = '0;
    rot_nxt.side.x_neg = x_neg;
    rot_nxt.side.y_neg = y_neg;
    rot_nxt.side.zero  = (x_mag == '0) && (y_mag == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r <= rot_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_rot   = rot_r;

endmodule

`default_nettype wire

### hw/rtl/vd2_cordic.sv
`default_nettype none

module vd2_cordic import vd2_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_valid,
  input  vd2_rot_t in_rot,
  output logic     out_valid,
  output vd2_rot_t out_rot
);

  logic [NUM_STEPS-1:0] valid_r;
  vd2_rot_t             rot_r [NUM_STEPS];

  // One vectoring micro-rotation per register stage
  for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
    vd2_rot_t               src;
    vd2_rot_t               rot_nxt;
    logic                   src_valid;
    logic signed [CX_W-1:0] dx, dy;

    if (i == 0) begin : g_first
      assign src       = in_rot;
      assign src_valid = in_valid;
    end else begin : g_next
      assign src       = rot_r[i-1];
      assign src_valid = valid_r[i-1];
    end

    always_comb begin
      dx = src.cy >>> i;
      dy = src.cx >>> i;
      rot_nxt.side = src.side;
      if (src.cy > 0) begin
        rot_nxt.cx = src.cx + dx;
        rot_nxt.cy = src.cy - dy;
        rot_nxt.z  = src.z + step_angle(i);
      end else begin
        rot_nxt.cx = src.cx - dx;
        rot_nxt.cy = src.cy + dy;
        rot_nxt.z  = src.z - step_angle(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else if (en) begin
        valid_r[i] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rot_r[i] <= rot_nxt;
      end
    end
  end

  assign out_valid = valid_r[NUM_STEPS-1];
  assign out_rot   = rot_r[NUM_STEPS-1];

endmodule

`default_nettype wire

### hw/rtl/vd2_scale.sv
`default_nettype none

module vd2_scale import vd2_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     deg_mode,
  input  logic     in_valid,
  input  vd2_rot_t in_rot,
  output logic     out_valid,
  output out_req_t out_res
);

  // Stage A: quadrant restore
  logic               a_valid_r;
  logic [A_W-1:0]     a_r;
  logic               a_zero_r;
  logic [A_W-1:0]     a_nxt;
  logic [A_W-2:0]     q;
  logic [A_W:0]       a_full;

  // Stage B: scale multiply
  logic               b_valid_r;
  logic [PROD_W-1:0]  prod_r;
  logic               b_zero_r;
  logic               b_deg_r;
  logic [A_W-1:0]     scale;

  logic [PROD_W:0]    rsum;
  logic [ANGLE_W-1:0] res;

  always_comb begin
    if (in_rot.z < 0) begin
      q = '0;
    end else if (in_rot.z > QUARTER_TURN) begin
      q = QUARTER_TURN[A_W-2:0];
    end else begin
      q = in_rot.z[A_W-2:0];
    end

    case ({in_rot.side.x_neg, in_rot.side.y_neg})
      2'b00:   a_full = {2'b00, q};
      2'b10:   a_full = HALF_TURN - {2'b00, q};
      2'b11:   a_full = HALF_TURN + {2'b00, q};
      default: a_full = FULL_TURN - {2'b00, q};
    endcase

    if (in_rot.side.zero || a_full[A_W]) begin
      a_nxt = '0;
    end else begin
      a_nxt = a_full[A_W-1:0];
    end
  end

  assign scale = deg_mode ? DEG_SCALE : RAD_SCALE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r      <= a_nxt;
      a_zero_r <= in_rot.side.zero;
      prod_r   <= a_r * scale;
      b_zero_r <= a_zero_r;
      b_deg_r  <= deg_mode;
    end
  end

  // Round to nearest and wrap the full-scale value to zero
  always_comb begin
    if (b_deg_r) begin
      rsum = {1'b0, prod_r} + (65'd1 << 31);
      res  = rsum[32 +: ANGLE_W];
      if (res >= DEG_FULL) begin
        res = '0;
      end
    end else begin
      rsum = {1'b0, prod_r} + (65'd1 << 47);
      res  = rsum[48 +: ANGLE_W];
      if (res >= RAD_FULL) begin
        res = '0;
      end
    end
  end

  assign out_valid           = b_valid_r;
  assign out_res.angle       = res;
  assign out_res.zero_vector = b_zero_r;

endmodule

`default_nettype wire

### hw/rtl/vector_direction_2d_top.sv
`default_nettype none

// Full-circle direction of a signed 2D vector (x, y): 0 along +x, rising
// counter-clockwise to just below one turn. cfg_write_data selects the
// format (0: radians, unsigned Q3.13; 1: degrees, unsigned Q9.7; reset 0)
// and may only be written while no request is in flight. Each result is
// rounded to the nearest LSB and a full turn wraps to 0; the zero vector
// returns angle 0 with zero_vector set. One request is taken per clock
// while in_stall is low. From acceptance to out_valid a request passes
// one input stage, 32 CORDIC micro-rotation stages, a quadrant-restore
// stage, a scaling multiply stage, then the output register. The output
// side holds up to two finished results (output register plus skid
// register); in_stall is raised only while the skid register is
// occupied, and the whole pipe freezes for that time.

module vector_direction_2d_top import vd2_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_data,
  input  logic     cfg_write_en,
  input  logic     cfg_write_data
);

  logic     deg_mode_r;
  logic     en;

  logic     front_valid;
  vd2_rot_t front_rot;
  logic     cordic_valid;
  vd2_rot_t cordic_rot;
  logic     res_valid;
  out_req_t res;

  // output register plus skid register
  logic     out_valid_r;
  out_req_t out_data_r;
  logic     skid_valid_r;
  out_req_t skid_data_r;
  logic     push, pop;

  // Pipe advances whenever the skid slot is free, so the last stage
  // always has a place to land.
  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_mode_r <= 1'b0;
    end else if (cfg_write_en) begin
      deg_mode_r <= cfg_write_data;
    end
  end

  vd2_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (front_valid),
    .out_rot   (front_rot)
  );

  vd2_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (front_valid),
    .in_rot    (front_rot),
    .out_valid (cordic_valid),
    .out_rot   (cordic_rot)
  );

  vd2_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .deg_mode  (deg_mode_r),
    .in_valid  (cordic_valid),
    .in_rot    (cordic_rot),
    .out_valid (res_valid),
    .out_res   (res)
  );

  assign push = en && res_valid;
  assign pop  = out_valid_r && !out_stall;

  // Output buffering: a new result goes to the output register when it
  // is empty or draining, otherwise it parks in the skid register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_data_r <= res;
      end else begin
        out_data_r <= res;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // skid slot only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  // draining the skid keeps a result on the output
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_stall |=> out_valid_r && !skid_valid_r)
    else $error("skid drain lost a result");

  a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.zero_vector |-> out_data_r.angle == '0)
    else $error("zero vector with nonzero angle");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.angle < RAD_FULL)
    else $error("angle at or beyond full scale");

endmodule

`default_nettype wire

### dv/tb_vector_direction_2d_top.sv
`timescale 1ns / 100ps

// Direction-angle checker for vector_direction_2d_top.
// Requests come off a backlog queue that the sequence block fills.
// Each accepted request is predicted on the spot with a local CORDIC copy.
// Results are compared in order, allowing one LSB either way around the circle.

module tb_vector_direction_2d_top;
  import vd2_pkg::*;

  localparam int CLK_HALF    = 2;       // 4 ns period
  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_WAIT  = 48;      // pipe latency plus skid slack
  localparam int PHASE_ITEMS = 158;     // six random phases, about 950 requests

  // Idle profiles: sender-heavy stalls, receiver-heavy stalls, free running
  localparam int IDLE_RECV_HEAVY = 0;
  localparam int IDLE_SEND_HEAVY = 1;
  localparam int IDLE_NONE       = 2;

  localparam logic FMT_RADIANS = 1'b0;
  localparam logic FMT_DEGREES = 1'b1;

  localparam longint unsigned HALF_TURN_U = 64'h8000_0000;
  localparam longint unsigned FULL_TURN_U = 64'h1_0000_0000;
  localparam longint          QUARTER_U   = 64'h4000_0000;

  // atan(2^-i) in 2^-32 turn units
  localparam longint TURN_STEP [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  // Directed vectors: zero, the four axes, the diagonals at full scale,
  // a vector just below one turn (rounds to full scale, must wrap to 0),
  // just past pi, and tiny magnitudes.
  localparam int DIR_COUNT = 13;
  localparam int DIR_X [DIR_COUNT] = '{
    0, 32767, -32768, 0, 0, 32767, -32768, -32768, 32767, -32768, 32767, -1, 1
  };
  localparam int DIR_Y [DIR_COUNT] = '{
    0, 0, 0, 32767, -32768, -1, -1, -32768, 32767, 32767, -32768, 0, -1
  };

  localparam int EDGE_VALS [5] = '{-32768, 32767, -1, 0, 1};

  logic     clk            = 1'b0;
  logic     rst_n          = 1'b0;
  logic     in_valid       = 1'b0;
  logic     in_stall;
  in_req_t  in_data        = '0;
  logic     out_valid;
  logic     out_stall      = 1'b0;
  out_req_t out_data;
  logic     cfg_write_en   = 1'b0;
  logic     cfg_write_data = 1'b0;

  in_req_t  vector_backlog[$];   // requests not yet offered
  out_req_t pending_angles[$];   // predicted results, oldest first
  logic     angle_deg = FMT_RADIANS;  // local copy of the format register
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       error_count   = 0;
  int       cycle_count   = 0;

  vector_direction_2d_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Full-circle angle of one vector in the given format.
  function automatic out_req_t direction_of(input in_req_t v, input logic deg);
    out_req_t        r;
    logic            x_neg;
    logic            y_neg;
    longint          ax;
    longint          ay;
    longint          cx;
    longint          cy;
    longint          z;
    longint          dx;
    longint          dy;
    longint unsigned a;
    longint unsigned q;
    x_neg = v.x_value[COMPONENT_BITS-1];
    y_neg = v.y_value[COMPONENT_BITS-1];
    ax = longint'(v.x_value);
    ay = longint'(v.y_value);
    if (x_neg) ax = -ax;
    if (y_neg) ay = -ay;
    r = '0;
    if (ax == 0 && ay == 0) begin
      r.zero_vector = 1'b1;
      return r;
    end
    // vectoring: drive cy to zero, accumulate the rotation in z
    cx = ax <<< PRE_SHIFT;
    cy = ay <<< PRE_SHIFT;
    z  = 0;
    for (int i = 0; i < NUM_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy > 0) begin
        cx = cx + dx;
        cy = cy - dy;
        z  = z + TURN_STEP[i];
      end else begin
        cx = cx - dx;
        cy = cy + dy;
        z  = z - TURN_STEP[i];
      end
    end
    if (z < 0) z = 0;
    if (z > QUARTER_U) z = QUARTER_U;
    // restore the quadrant
    case ({x_neg, y_neg})
      2'b00:   a = longint'(z);
      2'b10:   a = HALF_TURN_U - longint'(z);
      2'b11:   a = HALF_TURN_U + longint'(z);
      default: a = FULL_TURN_U - longint'(z);
    endcase
    if (a >= FULL_TURN_U) a = 0;
    if (deg) begin
      q = (a * longint'(DEG_SCALE) + (64'd1 << 31)) >> 32;
      if (q >= longint'(DEG_FULL)) q = 0;
    end else begin
      q = (a * longint'(RAD_SCALE) + (64'd1 << 47)) >> 48;
      if (q >= longint'(RAD_FULL)) q = 0;
    end
    r.angle = q[ANGLE_W-1:0];
    return r;
  endfunction

  // One LSB of slack, measured around the circle so 0 and full-1 are neighbors.
  function automatic bit angle_close(input out_req_t want, input out_req_t got,
                                     input logic deg);
    int full;
    int diff;
    full = deg ? int'(DEG_FULL) : int'(RAD_FULL);
    if (got.zero_vector !== want.zero_vector) return 1'b0;
    if (int'(got.angle) >= full) return 1'b0;
    diff = (int'(got.angle) - int'(want.angle) + full) % full;
    return diff == 0 || diff == 1 || diff == full - 1;
  endfunction

  // Random vector, biased toward axes, diagonals, tiny and extreme values.
  function automatic in_req_t random_vector();
    in_req_t            v;
    int                 kind;
    logic signed [15:0] m;
    logic signed [15:0] s;
    kind = $urandom_range(0, 9);
    m = 16'($urandom);
    s = 16'(int'($urandom_range(0, 4)) - 2);
    case (kind)
      5: begin  // tiny magnitudes, incl. zero
        v.x_value = 16'(int'($urandom_range(0, 8)) - 4);
        v.y_value = 16'(int'($urandom_range(0, 8)) - 4);
      end
      6: begin  // on an axis
        v.x_value = $urandom_range(0, 1) ? m : '0;
        v.y_value = v.x_value == m ? '0 : m;
      end
      7: begin  // just off an axis
        v.x_value = $urandom_range(0, 1) ? m : s;
        v.y_value = v.x_value == m ? s : m;
      end
      8: begin
        v.x_value = 16'(EDGE_VALS[$urandom_range(0, 4)]);
        v.y_value = 16'(EDGE_VALS[$urandom_range(0, 4)]);
      end
      9: begin  // diagonal, random signs
        v.x_value = $urandom_range(0, 1) ? -m : m;
        v.y_value = $urandom_range(0, 1) ? -m : m;
      end
      default: begin
        v.x_value = 16'($urandom);
        v.y_value = 16'($urandom);
      end
    endcase
    return v;
  endfunction

  // Request driver: hold the payload while stalled, otherwise maybe offer the
  // next one. Prediction happens at the accepting edge with the current format.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) pending_angles.push_back(direction_of(in_data, angle_deg));
      if (!in_valid || !in_stall) begin
        if (vector_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= vector_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor plus random backpressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_angles.size() == 0) begin
          error_count++;
          $display("%0t: expected nothing, got angle %0d zero %0b",
                   $time, out_data.angle, out_data.zero_vector);
        end else begin : compare
          out_req_t want;
          want = pending_angles.pop_front();
          if (!angle_close(want, out_data, angle_deg)) begin
            error_count++;
            $display("%0t: expected angle %0d zero %0b, got angle %0d zero %0b",
                     $time, want.angle, want.zero_vector,
                     out_data.angle, out_data.zero_vector);
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("vector_direction_2d_top: mismatch");
    $finish;
  end

  task automatic set_idle(input int profile);
    case (profile)
      IDLE_RECV_HEAVY: begin
        send_idle_pct = 27;
        recv_idle_pct = 71;
      end
      IDLE_SEND_HEAVY: begin
        send_idle_pct = 71;
        recv_idle_pct = 27;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // Nothing queued, nothing on the wire, nothing predicted but not yet seen.
  task automatic wait_drained();
    while (vector_backlog.size() != 0 || in_valid || pending_angles.size() != 0)
      @(posedge clk);
  endtask

  // Format register may only change with the pipe empty.
  task automatic set_angle_format(input logic deg);
    wait_drained();
    @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= deg;
    angle_deg      = deg;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  // Sequence: directed set in both formats, then random phases walking
  // through each idle profile with both formats.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int fmt = 0; fmt < 2; fmt++) begin
      set_idle(IDLE_RECV_HEAVY);
      set_angle_format(fmt == 0 ? FMT_RADIANS : FMT_DEGREES);
      for (int k = 0; k < DIR_COUNT; k++) begin : directed
        in_req_t v;
        v.x_value = 16'(DIR_X[k]);
        v.y_value = 16'(DIR_Y[k]);
        vector_backlog.push_back(v);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      set_idle(ph < 2 ? IDLE_RECV_HEAVY : (ph < 4 ? IDLE_SEND_HEAVY : IDLE_NONE));
      set_angle_format(ph % 2 == 0 ? FMT_DEGREES : FMT_RADIANS);
      repeat (PHASE_ITEMS) vector_backlog.push_back(random_vector());
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_angles.size() != 0) begin
      error_count++;
      $display("%0t: expected %0d more results, got none",
               $time, pending_angles.size());
    end

    if (error_count == 0) begin
      $display("vector_direction_2d_top: match");
    end else begin
      $display("vector_direction_2d_top: mismatch");
    end
    $finish;
  end

endmodule
